### sv/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg - serial packet framer package
// Field widths, action codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned TOPIC_W     = 16;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned S_TDATA_W   = 40;   // topic, length, data byte
  localparam int unsigned MAX_RESULTS = 8;    // seven header bytes plus checksum
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned REG_IDX_W   = 1;

  localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'hFF;
  localparam logic [BYTE_W-1:0] VERSION_RESET = 8'hFE;

  typedef enum logic {
    ACTION_START = 1'b0,
    ACTION_DATA  = 1'b1
  } action_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SYNC    = 1'b0,
    REG_VERSION = 1'b1
  } reg_idx_t;

  typedef logic [BYTE_W-1:0] byte_t;

  // checksum is 255 minus the byte sum modulo 256, i.e. the complement
  function automatic byte_t csum_of(input byte_t sum);
    return ~sum;
  endfunction

endpackage

### sv/serial_packet_framer_unit.sv
// ----------------------------------------------------------------------------
// serial_packet_framer_unit - serial packet framer
// Turns start items and payload bytes into a framed, checksummed byte stream.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          contents
//  --------  ---  -----------------  -------------------------------------------
//  s_*       in   s_tvalid/s_tready  tuser: action; tdata: topic, length, byte
//  m_*       out  m_tvalid/m_tready  tdata: framed byte; tlast: packet end
//  cfg_*     in   cfg_we             cfg_index selects sync or version byte
//
//  An accepted item is expanded at once into a result buffer (0, 1, 2, 7 or 8
//  bytes); the buffer drains one byte per cycle into the output register
//  unless m_tready stalls it. Payload bytes therefore flow at one transfer per
//  cycle when not stalled; a start item holds s_tready low while the header
//  drains. A new item is taken in the cycle the last buffered byte moves out.
//  Dropped payload bytes (outside a packet) are accepted and produce nothing.
//  rst is synchronous, active high; it empties the buffer and output register
//  and returns the framer to idle with default sync and version bytes.
//
module serial_packet_framer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave side
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [spf_pkg::S_TDATA_W-1:0]        s_tdata,  // topic_id, payload_length, data_byte
  input  logic [0:0]                           s_tuser,  // action
  // master side
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [spf_pkg::BYTE_W-1:0]           m_tdata,  // out_byte
  output logic                                 m_tlast,  // packet_end
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [spf_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [spf_pkg::BYTE_W-1:0]           cfg_data
);

  import spf_pkg::*;

  // configuration
  byte_t sync_byte;
  byte_t version_byte;

  // framing state
  logic [LEN_W-1:0] bytes_left;
  byte_t            data_sum;
  logic             in_packet;

  // result buffer: entry 0 is the next byte out
  byte_t            rbuf [MAX_RESULTS];
  logic [CNT_W-1:0] wcnt;
  logic             wend;

  // decode of the item on the slave side
  logic [TOPIC_W-1:0] in_topic;
  logic [LEN_W-1:0]   in_len;
  byte_t              in_data;
  action_t            in_action;

  assign in_topic  = s_tdata[TOPIC_W-1:0];
  assign in_len    = s_tdata[TOPIC_W+LEN_W-1:TOPIC_W];
  assign in_data   = s_tdata[S_TDATA_W-1:TOPIC_W+LEN_W];
  assign in_action = action_t'(s_tuser[0]);

  logic out_free;
  logic emit;
  logic accept;

  assign out_free = !m_tvalid || m_tready;
  assign emit     = (wcnt != '0) && out_free;
  // ready once the buffer is empty or its last byte leaves this cycle
  assign s_tready = (wcnt == '0) || ((wcnt == CNT_W'(1)) && out_free);
  assign accept   = s_tvalid && s_tready;

  // expansion of one item into results and the next framing state
  byte_t              nbuf [MAX_RESULTS];
  logic [CNT_W-1:0]   ncnt;
  logic               nend;
  logic [LEN_W-1:0]   bytes_left_next;
  byte_t              data_sum_next;
  logic               in_packet_next;
  byte_t              len_lo, len_hi, top_lo, top_hi;
  byte_t              topic_sum, pay_sum;
  logic [LEN_W-1:0]   left_dec;

  always_comb begin
    len_lo    = in_len[BYTE_W-1:0];
    len_hi    = in_len[LEN_W-1:BYTE_W];
    top_lo    = in_topic[BYTE_W-1:0];
    top_hi    = in_topic[TOPIC_W-1:BYTE_W];
    topic_sum = top_lo + top_hi;
    pay_sum   = data_sum + in_data;
    left_dec  = bytes_left - LEN_W'(1);

    for (int i = 0; i < MAX_RESULTS; i++) begin
      nbuf[i] = '0;
    end
    ncnt            = '0;
    nend            = 1'b0;
    bytes_left_next = bytes_left;
    data_sum_next   = data_sum;
    in_packet_next  = in_packet;

    unique case (in_action)
      ACTION_START: begin
        // a start abandons any open packet
        nbuf[0] = sync_byte;
        nbuf[1] = version_byte;
        nbuf[2] = len_lo;
        nbuf[3] = len_hi;
        nbuf[4] = csum_of(len_lo + len_hi);
        nbuf[5] = top_lo;
        nbuf[6] = top_hi;
        nbuf[7] = csum_of(topic_sum);
        data_sum_next   = topic_sum;
        bytes_left_next = in_len;
        in_packet_next  = (in_len != '0);
        nend            = (in_len == '0);
        ncnt            = (in_len == '0) ? CNT_W'(MAX_RESULTS) : CNT_W'(MAX_RESULTS - 1);
      end
      ACTION_DATA: begin
        if (in_packet) begin
          nbuf[0]         = in_data;
          nbuf[1]         = csum_of(pay_sum);
          data_sum_next   = pay_sum;
          bytes_left_next = left_dec;
          in_packet_next  = (left_dec != '0);
          nend            = (left_dec == '0);
          ncnt            = (left_dec == '0) ? CNT_W'(2) : CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte    <= SYNC_RESET;
      version_byte <= VERSION_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SYNC:    sync_byte    <= cfg_data;
        REG_VERSION: version_byte <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // framing state, updated when the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      data_sum   <= '0;
      in_packet  <= 1'b0;
    end else if (accept) begin
      bytes_left <= bytes_left_next;
      data_sum   <= data_sum_next;
      in_packet  <= in_packet_next;
    end
  end

  // result buffer: load on accept, otherwise shift one byte per emit
  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt <= '0;
      wend <= 1'b0;
    end else if (accept) begin
      wcnt <= ncnt;
      wend <= nend;
    end else if (emit) begin
      wcnt <= wcnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rbuf <= nbuf;
    end else if (emit) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        rbuf[i] <= rbuf[i+1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= (wcnt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= rbuf[0];
      m_tlast <= wend && (wcnt == CNT_W'(1));
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_count: assert property (@(posedge clk) disable iff (rst)
    !in_packet |-> (bytes_left == '0))
    else $error("bytes_left nonzero while idle");

  a_open_has_count: assert property (@(posedge clk) disable iff (rst)
    in_packet |-> (bytes_left != '0))
    else $error("packet open with no bytes left");

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    wcnt <= CNT_W'(MAX_RESULTS))
    else $error("result buffer count out of range");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_tvalid)
    else $error("emitted byte not presented");

  a_last_only_end: assert property (@(posedge clk) disable iff (rst)
    (emit && !wend) |=> !m_tlast)
    else $error("tlast on a byte that does not end a packet");
`endif

endmodule
